// ===== rtl/lsrs_pkg.sv =====
// ---------------------------------------------------------------------------
// lsrs_pkg
// Shared types, script table and constants of the light sensor read sequencer.
// ---------------------------------------------------------------------------
package lsrs_pkg;

	// register file geometry
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int REG_IDX_W = 3;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_DEV_ADDR  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_POWER_CMD = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MODE_CMD  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CONV_WAIT = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_POST_WAIT = 3'd4;

	// register reset values
	localparam logic [7:0]  DEV_ADDR_RST  = 8'h46;
	localparam logic [7:0]  POWER_CMD_RST = 8'h01;
	localparam logic [7:0]  MODE_CMD_RST  = 8'h10;
	localparam logic [15:0] CONV_WAIT_RST = 16'd36000;
	localparam logic [15:0] POST_WAIT_RST = 16'd1000;

	// script phase and element kinds
	localparam int PHASE_W = 5;
	localparam logic [PHASE_W-1:0] PHASE_IDLE  = 5'd0;
	localparam logic [PHASE_W-1:0] PHASE_FIRST = 5'd1;

	typedef logic [3:0] kind_t;
	localparam kind_t EL_IDLE  = 4'd0;
	localparam kind_t EL_START = 4'd1;
	localparam kind_t EL_WBYTE = 4'd2;
	localparam kind_t EL_RACK  = 4'd3;
	localparam kind_t EL_RBYTE = 4'd4;
	localparam kind_t EL_SACK  = 4'd5;
	localparam kind_t EL_STOP  = 4'd6;
	localparam kind_t EL_WAIT  = 4'd7;
	localparam kind_t EL_DONE  = 4'd8;

	// byte sources for a write byte
	localparam logic [1:0] SRC_ADDR_WR = 2'd0;
	localparam logic [1:0] SRC_POWER   = 2'd1;
	localparam logic [1:0] SRC_MODE    = 2'd2;
	localparam logic [1:0] SRC_ADDR_RD = 2'd3;

	// last half-bit index of a byte element and of a two-tick element
	localparam logic [3:0] BIT_LAST_BYTE = 4'd15;
	localparam logic [3:0] BIT_LAST_PAIR = 4'd1;

	// lux = raw * 5 / 6 as a reciprocal multiply, exact over 16 bits
	localparam int LUX_SHIFT = 22;
	localparam int LUX_MULT_W = 22;
	localparam logic [LUX_MULT_W-1:0] LUX_MULT = 22'd3495255;
	localparam int LUX_PROD_W = 16 + LUX_MULT_W;

	typedef struct packed {
		logic [7:0]  dev_addr;
		logic [7:0]  power_cmd;
		logic [7:0]  mode_cmd;
		logic [15:0] conv_wait;
		logic [15:0] post_wait;
	} cfg_t;

	typedef struct packed {
		logic        scl;
		logic        sda_lvl;
		logic        sda_drv;
		logic        busy;
		logic        done;
		logic [15:0] raw;
		logic [15:0] lux;
		logic        nack;
	} res_t;

	// element kind of each script phase
	function automatic kind_t phase_kind(input logic [PHASE_W-1:0] p);
		kind_t k;
		case (p)
			5'd1, 5'd7, 5'd14:                  k = EL_START;
			5'd2, 5'd4, 5'd8, 5'd10, 5'd15:     k = EL_WBYTE;
			5'd3, 5'd5, 5'd9, 5'd11, 5'd16:     k = EL_RACK;
			5'd17, 5'd19:                       k = EL_RBYTE;
			5'd18, 5'd20:                       k = EL_SACK;
			5'd6, 5'd12, 5'd21:                 k = EL_STOP;
			5'd13, 5'd22:                       k = EL_WAIT;
			5'd23:                              k = EL_DONE;
			default:                            k = EL_IDLE;
		endcase
		return k;
	endfunction

	// element argument: byte source, ack level or wait select
	function automatic logic [1:0] phase_arg(input logic [PHASE_W-1:0] p);
		logic [1:0] a;
		case (p)
			5'd4:         a = SRC_POWER;
			5'd10:        a = SRC_MODE;
			5'd15:        a = SRC_ADDR_RD;
			5'd20, 5'd22: a = 2'd1;
			default:      a = 2'd0;
		endcase
		return a;
	endfunction

endpackage

// ===== rtl/lsrs_apb_regs.sv =====
// ---------------------------------------------------------------------------
// lsrs_apb_regs
// APB register file holding the sequencer's addresses, commands and waits.
// ---------------------------------------------------------------------------
module lsrs_apb_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lsrs_pkg::ADDR_W-1:0]   paddr,
	input  logic [lsrs_pkg::DATA_W-1:0]   pwdata,
	output logic [lsrs_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output lsrs_pkg::cfg_t                cfg
);
	import lsrs_pkg::*;

	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;
	cfg_t                 cfg_q;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dev_addr  <= DEV_ADDR_RST;
			cfg_q.power_cmd <= POWER_CMD_RST;
			cfg_q.mode_cmd  <= MODE_CMD_RST;
			cfg_q.conv_wait <= CONV_WAIT_RST;
			cfg_q.post_wait <= POST_WAIT_RST;
		end else if (wr_en) begin
			case (idx)
				REG_DEV_ADDR:  cfg_q.dev_addr  <= pwdata[7:0];
				REG_POWER_CMD: cfg_q.power_cmd <= pwdata[7:0];
				REG_MODE_CMD:  cfg_q.mode_cmd  <= pwdata[7:0];
				REG_CONV_WAIT: cfg_q.conv_wait <= pwdata[15:0];
				REG_POST_WAIT: cfg_q.post_wait <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_DEV_ADDR:  prdata = {24'd0, cfg_q.dev_addr};
			REG_POWER_CMD: prdata = {24'd0, cfg_q.power_cmd};
			REG_MODE_CMD:  prdata = {24'd0, cfg_q.mode_cmd};
			REG_CONV_WAIT: prdata = {16'd0, cfg_q.conv_wait};
			REG_POST_WAIT: prdata = {16'd0, cfg_q.post_wait};
			default:       prdata = '0;
		endcase
	end

endmodule

// ===== rtl/lsrs_core.sv =====
// ---------------------------------------------------------------------------
// lsrs_core
// Script state and one half-bit step of the I2C read sequence per tick.
// ---------------------------------------------------------------------------
module lsrs_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step_en,
	input  logic           start_request,
	input  logic           sda_in,
	input  lsrs_pkg::cfg_t cfg,
	output lsrs_pkg::res_t res
);
	import lsrs_pkg::*;

	logic [PHASE_W-1:0] phase_q, phase_d;
	logic [3:0]         bit_q, bit_d;
	logic [7:0]         shift_q, shift_d;
	logic [15:0]        word_q, word_d;
	logic [15:0]        wait_q, wait_d;
	logic [15:0]        lux_q, lux_d;
	logic               nack_q, nack_d;

	logic [PHASE_W-1:0] cur_phase, nxt_phase;
	logic               start_now, active, high_half, last_step;
	kind_t              kind, nxt_kind;
	logic [1:0]         arg, nxt_arg;
	logic [15:0]        wait_dec, nxt_wait;
	logic [LUX_PROD_W-1:0] lux_prod;
	logic [3:0]         cur_bit;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_IDLE;
			bit_q   <= '0;
			shift_q <= '0;
			word_q  <= '0;
			wait_q  <= '0;
			lux_q   <= '0;
			nack_q  <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			word_q  <= word_d;
			wait_q  <= wait_d;
			lux_q   <= lux_d;
			nack_q  <= nack_d;
		end
	end

	// a request while idle enters the first start element in the same tick
	assign start_now = (phase_q == PHASE_IDLE) && start_request;
	assign cur_phase = start_now ? PHASE_FIRST : phase_q;
	assign cur_bit   = start_now ? 4'd0 : bit_q;
	assign active    = (cur_phase != PHASE_IDLE);
	assign kind      = phase_kind(cur_phase);
	assign arg       = phase_arg(cur_phase);
	assign high_half = ~cur_bit[0];
	assign wait_dec  = wait_q - 16'd1;
	assign lux_prod  = LUX_PROD_W'(word_q) * LUX_PROD_W'(LUX_MULT);

	// following element, stepping over a wait of zero length
	always_comb begin
		nxt_phase = cur_phase + 5'd1;
		nxt_kind  = phase_kind(nxt_phase);
		nxt_arg   = phase_arg(nxt_phase);
		nxt_wait  = nxt_arg[0] ? cfg.post_wait : cfg.conv_wait;
		if (nxt_kind == EL_WAIT && nxt_wait == 16'd0) begin
			nxt_phase = nxt_phase + 5'd1;
		end
	end

	// end of the current element
	always_comb begin
		case (kind)
			EL_WBYTE, EL_RBYTE: last_step = (cur_bit == BIT_LAST_BYTE);
			EL_WAIT:            last_step = (wait_dec == 16'd0);
			default:            last_step = (cur_bit == BIT_LAST_PAIR);
		endcase
	end

	// bus drive and state update for this half bit
	always_comb begin
		res.scl     = 1'b1;
		res.sda_lvl = 1'b1;
		res.sda_drv = 1'b1;
		res.busy    = active;
		res.done    = 1'b0;
		phase_d = cur_phase;
		bit_d   = cur_bit;
		shift_d = shift_q;
		word_d  = word_q;
		wait_d  = wait_q;
		lux_d   = lux_q;
		nack_d  = start_now ? 1'b0 : nack_q;

		if (active) begin
			case (kind)
				EL_START: res.sda_lvl = high_half;
				EL_WBYTE: begin
					res.scl     = high_half;
					res.sda_lvl = shift_q[7];
					if (!high_half) shift_d = {shift_q[6:0], 1'b0};
				end
				EL_RACK, EL_RBYTE: begin
					if (high_half) begin
						res.sda_drv = 1'b0;
						if (kind == EL_RACK) begin
							if (sda_in) nack_d = 1'b1;
						end else begin
							word_d = {word_q[14:0], sda_in};
						end
					end else begin
						res.scl = 1'b0;
					end
				end
				EL_SACK: begin
					res.scl     = high_half;
					res.sda_lvl = arg[0];
				end
				EL_STOP: res.sda_lvl = ~high_half;
				EL_WAIT: ;
				EL_DONE: begin
					res.busy = 1'b0;
					res.done = 1'b1;
					lux_d    = lux_prod[LUX_PROD_W-1:LUX_SHIFT];
				end
				default: ;
			endcase

			// sequencing
			if (kind == EL_DONE) begin
				phase_d = PHASE_IDLE;
				bit_d   = '0;
			end else begin
				if (kind == EL_WAIT) wait_d = wait_dec;
				else                 bit_d  = cur_bit + 4'd1;
				if (last_step) begin
					phase_d = nxt_phase;
					bit_d   = '0;
					if (phase_kind(nxt_phase) == EL_WAIT) wait_d = nxt_wait;
					if (phase_kind(nxt_phase) == EL_WBYTE) begin
						case (phase_arg(nxt_phase))
							SRC_ADDR_WR: shift_d = cfg.dev_addr;
							SRC_POWER:   shift_d = cfg.power_cmd;
							SRC_MODE:    shift_d = cfg.mode_cmd;
							default:     shift_d = cfg.dev_addr + 8'd1;
						endcase
					end
				end
			end
		end

		res.raw  = word_d;
		res.lux  = lux_d;
		res.nack = nack_d;
	end

endmodule

// ===== rtl/light_sensor_i2c_read_sequencer.sv =====
// ---------------------------------------------------------------------------
// light_sensor_i2c_read_sequencer
// Tick-driven I2C master that powers up a light sensor and reads its count.
// ---------------------------------------------------------------------------
// Usage: each input item is one 5 us tick carrying start_request and the
// sampled sda_in. Every item gives exactly one result item with the SCL
// level, SDA level and drive for that tick, busy/done flags, the raw count,
// the lux value (raw*5/6) and a sticky NACK flag.
// Input items enter an input register; the step logic then updates the
// script state and loads the result register, which offers the result to
// the receiver.
// One item is taken per cycle while the receiver does not stall, since the
// step between the input and result registers is combinational.
// When the receiver stalls, the result register holds, the input register
// fills, and in_stall rises until the result is taken; nothing is dropped.
// At reset the script is idle, its state is zero and the configuration
// registers take their defaults; the APB port always answers at once.
// ---------------------------------------------------------------------------
module light_sensor_i2c_read_sequencer (
	input  logic                        clk,
	input  logic                        arst_n,
	// tick channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        start_request,
	input  logic                        sda_in,
	// result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        scl_level,
	output logic                        sda_level,
	output logic                        sda_drive,
	output logic                        busy_res,
	output logic                        done_res,
	output logic [15:0]                 raw_count,
	output logic [15:0]                 lux_value,
	output logic                        nack_seen,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lsrs_pkg::ADDR_W-1:0] paddr,
	input  logic [lsrs_pkg::DATA_W-1:0] pwdata,
	output logic [lsrs_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import lsrs_pkg::*;

	cfg_t cfg;
	res_t res_step;
	res_t res_s2;
	logic valid_s1, start_s1, sda_s1;
	logic valid_s2;
	logic advance;

	lsrs_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// step proceeds when the result register is free or being emptied
	assign advance  = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & ~advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			start_s1 <= start_request;
			sda_s1   <= sda_in;
		end
	end

	lsrs_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_en       (advance),
		.start_request (start_s1),
		.sda_in        (sda_s1),
		.cfg           (cfg),
		.res           (res_step)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_step;
		end
	end

	assign out_valid = valid_s2;
	assign scl_level = res_s2.scl;
	assign sda_level = res_s2.sda_lvl;
	assign sda_drive = res_s2.sda_drv;
	assign busy_res  = res_s2.busy;
	assign done_res  = res_s2.done;
	assign raw_count = res_s2.raw;
	assign lux_value = res_s2.lux;
	assign nack_seen = res_s2.nack;

endmodule

// ===== tb/sv/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the light sensor I2C read sequencer.
// ---------------------------------------------------------------------------
// Ticks go in over the valid/stall channel and every tick gives one result
// item. A tick-accurate model of the I2C script runs beside the block: it
// predicts the result of each accepted tick, and each result taken from
// the block is checked against the oldest prediction. A short table of
// ticks after reset comes first. Then whole measurements run under several
// settings: random bytes with short waits, zero bytes with zero waits and
// all-ones bytes. The SDA line is random, held low or held high. Both
// channels idle at random, with a stretch at full rate.
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lsrs_pkg::*;

	localparam int DIR_N    = 25;
	localparam int SEQ_LEN  = 24;
	localparam int PIPE_LAT = 2;

	typedef enum int {SDA_RAND, SDA_LOW, SDA_HIGH} sda_mode_e;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                start_request = 1'b0;
	logic                sda_in = 1'b1;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                scl_level;
	logic                sda_level;
	logic                sda_drive;
	logic                busy_res;
	logic                done_res;
	logic [15:0]         raw_count;
	logic [15:0]         lux_value;
	logic                nack_seen;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	// model state and its copy of the registers
	cfg_t        cur_cfg = {DEV_ADDR_RST, POWER_CMD_RST, MODE_CMD_RST,
	                        CONV_WAIT_RST, POST_WAIT_RST};
	int          m_phase = 0;
	int          m_bit = 0;
	logic [7:0]  m_shift = '0;
	logic [15:0] m_word = '0;
	logic [15:0] m_wait = '0;
	logic [15:0] m_lux = '0;
	logic        m_nack = 1'b0;

	res_t        tick_results_due [$];
	res_t        typed_res [DIR_N];
	bit          typed_row [DIR_N];
	int          ticks_taken = 0;
	int          done_pred = 0;
	int          err_count = 0;
	bit          calm = 1'b0;
	int          hold_cnt = 0;
	bit          stall_now;
	res_t        tick_want;
	res_t        got;
	res_t        want;

	light_sensor_i2c_read_sequencer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.start_request(start_request),
		.sda_in       (sda_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.scl_level    (scl_level),
		.sda_level    (sda_level),
		.sda_drive    (sda_drive),
		.busy_res     (busy_res),
		.done_res     (done_res),
		.raw_count    (raw_count),
		.lux_value    (lux_value),
		.nack_seen    (nack_seen),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// element kind of each script step
	function automatic kind_t seq_kind(input int p);
		case (p)
			1, 7, 14:          return EL_START;
			2, 4, 8, 10, 15:   return EL_WBYTE;
			3, 5, 9, 11, 16:   return EL_RACK;
			17, 19:            return EL_RBYTE;
			18, 20:            return EL_SACK;
			6, 12, 21:         return EL_STOP;
			13, 22:            return EL_WAIT;
			23:                return EL_DONE;
			default:           return EL_IDLE;
		endcase
	endfunction

	// byte source, master ack level or wait select of each step
	function automatic logic [1:0] seq_arg(input int p);
		case (p)
			4:       return SRC_POWER;
			10:      return SRC_MODE;
			15:      return SRC_ADDR_RD;
			20, 22:  return 2'd1;
			default: return SRC_ADDR_WR;
		endcase
	endfunction

	// step to the next element, load its byte or wait, skip empty waits
	function automatic void seq_advance();
		bit settled;
		settled = 1'b0;
		while (!settled) begin
			m_phase++;
			m_bit = 0;
			if (m_phase >= SEQ_LEN) begin
				m_phase = 0;
				settled = 1'b1;
			end else if (seq_kind(m_phase) == EL_WBYTE) begin
				case (seq_arg(m_phase))
					SRC_ADDR_WR: m_shift = cur_cfg.dev_addr;
					SRC_POWER:   m_shift = cur_cfg.power_cmd;
					SRC_MODE:    m_shift = cur_cfg.mode_cmd;
					default:     m_shift = cur_cfg.dev_addr + 8'd1;
				endcase
				settled = 1'b1;
			end else if (seq_kind(m_phase) == EL_WAIT) begin
				m_wait = (seq_arg(m_phase) != 2'd0) ? cur_cfg.post_wait : cur_cfg.conv_wait;
				settled = (m_wait != 16'd0);
			end else begin
				settled = 1'b1;
			end
		end
	endfunction

	// bus levels and flags of one tick, advancing the script
	function automatic res_t predict_tick(input logic st, input logic sd);
		res_t        r;
		kind_t       k;
		logic [1:0]  a;
		bit          hi;
		logic [31:0] prod;
		r = '0;
		r.scl = 1'b1;
		r.sda_lvl = 1'b1;
		r.sda_drv = 1'b1;
		r.busy = 1'b1;
		if (m_phase == 0) begin
			if (st) begin
				m_nack = 1'b0;
				m_phase = 1;
				m_bit = 0;
			end else begin
				r.busy = 1'b0;
			end
		end
		if (m_phase != 0) begin
			k = seq_kind(m_phase);
			a = seq_arg(m_phase);
			hi = ((m_bit & 1) == 0);
			case (k)
				EL_START: r.sda_lvl = hi;
				EL_WBYTE: begin
					r.scl = hi;
					r.sda_lvl = m_shift[7];
					if (!hi) m_shift = {m_shift[6:0], 1'b0};
				end
				EL_RACK, EL_RBYTE: begin
					if (hi) begin
						r.sda_drv = 1'b0;
						if (k == EL_RACK) begin
							if (sd) m_nack = 1'b1;
						end else begin
							m_word = {m_word[14:0], sd};
						end
					end else begin
						r.scl = 1'b0;
					end
				end
				EL_SACK: begin
					r.scl = hi;
					r.sda_lvl = a[0];
				end
				EL_STOP: r.sda_lvl = !hi;
				EL_WAIT: ;
				default: begin
					r.busy = 1'b0;
					r.done = 1'b1;
					prod = {16'd0, m_word} * 32'd5;
					prod = prod / 32'd6;
					m_lux = prod[15:0];
				end
			endcase
			if (k == EL_WAIT) begin
				m_wait = m_wait - 16'd1;
				if (m_wait == 16'd0) seq_advance();
			end else if (k == EL_DONE) begin
				m_phase = 0;
				m_bit = 0;
			end else begin
				m_bit++;
				if (m_bit >= ((k == EL_WBYTE || k == EL_RBYTE) ? 16 : 2)) seq_advance();
			end
		end
		r.raw = m_word;
		r.lux = m_lux;
		r.nack = m_nack;
		return r;
	endfunction

	// bus-only result with zero count and lux
	function automatic res_t bus_res(input logic scl, input logic lvl, input logic drv,
	                                 input logic busy, input logic nack);
		res_t r;
		r = '0;
		r.scl = scl;
		r.sda_lvl = lvl;
		r.sda_drv = drv;
		r.busy = busy;
		r.nack = nack;
		return r;
	endfunction

	// directed ticks after reset: {start_request, sda_in}
	function automatic logic [1:0] dir_tick(input int i);
		case (i)
			0:       return 2'b00;  // idle, line low
			1:       return 2'b01;  // idle, line high
			2:       return 2'b11;  // request taken, start begins
			3:       return 2'b10;  // request while busy
			7:       return 2'b11;
			12:      return 2'b10;
			20:      return 2'b01;  // slave ack bit reads high
			21:      return 2'b00;
			22:      return 2'b10;
			default: return {1'b0, (i % 2) == 1};
		endcase
	endfunction

	function automatic int pick_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	function automatic void note_error(input string msg);
		err_count++;
		if (err_count <= 10) $display("tb: mismatch: %s", msg);
	endfunction

	function automatic cfg_t rand_cfg(input int wmax);
		cfg_t c;
		c.dev_addr = 8'($urandom);
		c.power_cmd = 8'($urandom);
		c.mode_cmd = 8'($urandom);
		c.conv_wait = 16'($urandom_range(0, wmax));
		c.post_wait = 16'($urandom_range(0, wmax));
		return c;
	endfunction

	// predict on each accepted tick, check each taken result
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				tick_want = predict_tick(start_request, sda_in);
				if (tick_want.done) done_pred++;
				if (ticks_taken < DIR_N && typed_row[ticks_taken]) tick_want = typed_res[ticks_taken];
				tick_results_due.push_back(tick_want);
				ticks_taken++;
			end
			if (out_valid && !out_stall) begin
				got.scl = scl_level;
				got.sda_lvl = sda_level;
				got.sda_drv = sda_drive;
				got.busy = busy_res;
				got.done = done_res;
				got.raw = raw_count;
				got.lux = lux_value;
				got.nack = nack_seen;
				if (tick_results_due.size() == 0) begin
					note_error("result item with no tick waiting");
				end else begin
					want = tick_results_due.pop_front();
					if (got !== want) begin
						note_error($sformatf({"exp/act scl %b/%b sda %b/%b drv %b/%b busy %b/%b ",
							"done %b/%b raw %h/%h lux %h/%h nack %b/%b"},
							want.scl, got.scl, want.sda_lvl, got.sda_lvl, want.sda_drv, got.sda_drv,
							want.busy, got.busy, want.done, got.done, want.raw, got.raw,
							want.lux, got.lux, want.nack, got.nack));
					end
				end
			end
		end
	end

	// receiver stalls: runs of random length, none in calm stretches
	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt--;
		end else begin
			stall_now = !calm && ($urandom_range(0, 2) == 0);
			hold_cnt = stall_now ? pick_gap() : $urandom_range(0, 6);
			out_stall <= stall_now;
		end
	end

	// one tick item, after a random gap
	task automatic send_tick(input logic st, input logic sd);
		int gap;
		gap = (calm || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_request <= st;
		sda_in <= sd;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// stop sending and let every outstanding result come back
	task automatic wait_quiet(input int extra);
		in_valid <= 1'b0;
		@(posedge clk);
		while (tick_results_due.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// register write: setup then access, followed by an idle gap
	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_DEV_ADDR:  cur_cfg.dev_addr = data[7:0];
			REG_POWER_CMD: cur_cfg.power_cmd = data[7:0];
			REG_MODE_CMD:  cur_cfg.mode_cmd = data[7:0];
			REG_CONV_WAIT: cur_cfg.conv_wait = data[15:0];
			REG_POST_WAIT: cur_cfg.post_wait = data[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// all five registers, with junk in the unused upper bits
	task automatic set_cfg(input cfg_t c);
		logic [DATA_W-1:0] noise;
		wait_quiet(PIPE_LAT + 2);
		noise = $urandom;
		apb_write(REG_DEV_ADDR, {noise[31:8], c.dev_addr});
		apb_write(REG_POWER_CMD, {noise[31:8], c.power_cmd});
		apb_write(REG_MODE_CMD, {noise[31:8], c.mode_cmd});
		apb_write(REG_CONV_WAIT, {noise[31:16], c.conv_wait});
		apb_write(REG_POST_WAIT, {noise[31:16], c.post_wait});
	endtask

	// random ticks until the given number of measurements has finished
	task automatic run_meas(input int n_meas, input sda_mode_e mode);
		int   target;
		logic st;
		logic sd;
		target = done_pred + n_meas;
		while (done_pred < target) begin
			st = ($urandom_range(0, 7) == 0);
			if (mode == SDA_RAND) sd = ($urandom_range(0, 1) == 1);
			else sd = (mode == SDA_HIGH);
			send_tick(st, sd);
		end
		repeat ($urandom_range(2, 8)) send_tick($urandom_range(0, 15) == 0, $urandom_range(0, 1) == 1);
	endtask

	// watchdog
	initial begin
		#10_000_000;
		$display("tb: done, errors");
		$finish;
	end

	// main sequence
	initial begin
		cfg_t       c;
		logic [1:0] row;
		int         i;
		int         u;
		typed_row[0] = 1'b1;
		typed_res[0] = bus_res(1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
		typed_row[1] = 1'b1;
		typed_res[1] = bus_res(1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
		typed_row[2] = 1'b1;
		typed_res[2] = bus_res(1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
		typed_row[3] = 1'b1;
		typed_res[3] = bus_res(1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
		typed_row[20] = 1'b1;
		typed_res[20] = bus_res(1'b1, 1'b1, 1'b0, 1'b1, 1'b1);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed ticks under the reset settings
		for (i = 0; i < DIR_N; i++) begin
			row = dir_tick(i);
			send_tick(row[1], row[0]);
		end

		// short waits set while the first measurement is under way
		c = rand_cfg(4);
		set_cfg(c);
		run_meas(1, SDA_RAND);

		// all-zero bytes and zero waits, line held low; unmapped registers written once
		c = '0;
		set_cfg(c);
		for (u = REG_POST_WAIT + 1; u < 2 ** REG_IDX_W; u++) begin
			apb_write(u[REG_IDX_W-1:0], $urandom);
		end
		run_meas(1, SDA_LOW);

		// all-ones bytes, read address wraps to zero, line held high, full rate
		c = {8'hFF, 8'hFF, 8'hFF, 16'd1, 16'd0};
		set_cfg(c);
		calm = 1'b1;
		run_meas(1, SDA_HIGH);
		calm = 1'b0;

		wait_quiet(PIPE_LAT + 8);
		if (err_count == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

// ===== light_sensor_i2c_read_sequencer.f =====
rtl/lsrs_pkg.sv
rtl/lsrs_apb_regs.sv
rtl/lsrs_core.sv
rtl/light_sensor_i2c_read_sequencer.sv
tb/sv/tb.sv
